@@ hdl/chunk_boundary_falloff_weight_unit_assert.svh @@
// Assertion macros shared by the chunk boundary falloff weight unit.
`ifndef CHUNK_BOUNDARY_FALLOFF_WEIGHT_UNIT_ASSERT_SVH
`define CHUNK_BOUNDARY_FALLOFF_WEIGHT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define CBFW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cbfw assertion failed");

// Next-cycle implication, disabled while reset is held.
`define CBFW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cbfw assertion failed");

`endif

@@ hdl/cbfw_pkg.sv @@
// Package with types and constants of the chunk boundary falloff weight unit.
`timescale 1ns / 1ps
package cbfw_pkg;
    localparam int MAX_CENTERS_DEF = 16;
    localparam int COORD_BITS_DEF  = 32;
    localparam int WEIGHT_BITS     = 17;
    localparam int FRAC_STEPS      = 15;
    localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 17'd65536;

    localparam logic REG_NUM_CENTERS = 1'b0;
    localparam logic REG_OWN_CHUNK   = 1'b1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_WEIGH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_DIVIDE,
        S_OUT
    } t_state;
endpackage

@@ hdl/cbfw_cell.sv @@
// One center cell of the rotating ring that holds the center table.
`timescale 1ns / 1ps
module cbfw_cell #(
    parameter int COORD_BITS = cbfw_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_shift,
    input  logic signed [COORD_BITS-1:0] i_load_x,
    input  logic signed [COORD_BITS-1:0] i_load_y,
    input  logic signed [COORD_BITS-1:0] i_load_z,
    input  logic signed [COORD_BITS-1:0] i_nb_x,
    input  logic signed [COORD_BITS-1:0] i_nb_y,
    input  logic signed [COORD_BITS-1:0] i_nb_z,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y,
    output logic signed [COORD_BITS-1:0] o_z
);
    import cbfw_pkg::*;

    logic signed [COORD_BITS-1:0] r_x, r_y, r_z;

    // Loads come only while the ring sits at home, so the two never meet.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
            r_z <= i_load_z;
        end else if (i_shift) begin
            r_x <= i_nb_x;
            r_y <= i_nb_y;
            r_z <= i_nb_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

@@ hdl/cbfw_dist.sv @@
// Pipelined Euclidean distance: differences, squares, sum and a bit-per-stage root.
`timescale 1ns / 1ps
module cbfw_dist #(
    parameter int COORD_BITS = cbfw_pkg::COORD_BITS_DEF,
    parameter int TAG_BITS   = 4,
    localparam int DW = COORD_BITS + 1,
    localparam int SW = 2 * DW + 2,
    localparam int RW = DW + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [TAG_BITS-1:0]          i_tag,
    input  logic signed [COORD_BITS-1:0] i_px,
    input  logic signed [COORD_BITS-1:0] i_py,
    input  logic signed [COORD_BITS-1:0] i_pz,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_cz,
    output logic                         o_valid,
    output logic [TAG_BITS-1:0]          o_tag,
    output logic [RW-1:0]                o_dist
);
    import cbfw_pkg::*;

    logic signed [DW-1:0] n_dx, n_dy, n_dz;
    logic [DW-1:0]        r_ax, r_ay, r_az;
    logic [2*DW-1:0]      r_sx, r_sy, r_sz;
    logic [SW-1:0]        r_sum;
    logic [2:0]           r_fv;
    logic [TAG_BITS-1:0]  r_ft [0:2];

    always_comb begin
        n_dx = DW'(i_px) - DW'(i_cx);
        n_dy = DW'(i_py) - DW'(i_cy);
        n_dz = DW'(i_pz) - DW'(i_cz);
    end

    always_ff @(posedge i_clk) begin
        r_ax  <= n_dx[DW-1] ? DW'(-n_dx) : DW'(n_dx);
        r_ay  <= n_dy[DW-1] ? DW'(-n_dy) : DW'(n_dy);
        r_az  <= n_dz[DW-1] ? DW'(-n_dz) : DW'(n_dz);
        r_sx  <= r_ax * r_ax;
        r_sy  <= r_ay * r_ay;
        r_sz  <= r_az * r_az;
        r_sum <= SW'(r_sx) + SW'(r_sy) + SW'(r_sz);
        r_ft[0] <= i_tag;
        r_ft[1] <= r_ft[0];
        r_ft[2] <= r_ft[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else begin
            r_fv <= {r_fv[1:0], i_valid};
        end
    end

    // Stage s settles root bit RW-1-s; the remainder is the sum less root squared.
    for (genvar s = 0; s < RW; s++) begin : g_root
        localparam int B = RW - 1 - s;
        logic [SW-1:0]       w_rem_in;
        logic [RW-1:0]       w_root_in;
        logic                w_vld_in;
        logic [TAG_BITS-1:0] w_tag_in;
        logic [SW-1:0]       n_trial;
        logic                n_take;
        logic [SW-1:0]       r_rem;
        logic [RW-1:0]       r_root;
        logic                r_vld;
        logic [TAG_BITS-1:0] r_tag;

        if (s == 0) begin : g_in
            assign w_rem_in  = r_sum;
            assign w_root_in = '0;
            assign w_vld_in  = r_fv[2];
            assign w_tag_in  = r_ft[2];
        end else begin : g_in
            assign w_rem_in  = g_root[s-1].r_rem;
            assign w_root_in = g_root[s-1].r_root;
            assign w_vld_in  = g_root[s-1].r_vld;
            assign w_tag_in  = g_root[s-1].r_tag;
        end

        always_comb begin
            n_trial = (SW'(w_root_in) << (B + 1)) | (SW'(1) << (2 * B));
            n_take  = (w_rem_in >= n_trial);
        end
        always_ff @(posedge i_clk) begin
            r_rem  <= n_take ? (w_rem_in - n_trial) : w_rem_in;
            r_root <= n_take ? (w_root_in | (RW'(1) << B)) : w_root_in;
            r_tag  <= w_tag_in;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_vld_in;
            end
        end
    end

    assign o_valid = g_root[RW-1].r_vld;
    assign o_tag   = g_root[RW-1].r_tag;
    assign o_dist  = g_root[RW-1].r_root;
endmodule

@@ hdl/cbfw_div.sv @@
// Bit-serial restoring divider for the falloff band: floor(num * 32768 / den).
`timescale 1ns / 1ps
module cbfw_div #(
    parameter int RW = 34,
    localparam int NW = RW + 5
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [NW-1:0]                      i_num,
    input  logic [RW-1:0]                      i_den,
    output logic                               o_done,
    output logic [cbfw_pkg::WEIGHT_BITS-1:0]   o_quot
);
    import cbfw_pkg::*;

    logic [WEIGHT_BITS-1:0] r_q;
    logic [RW:0]            r_r;
    logic [RW-1:0]          r_den;
    logic [3:0]             r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   n_q0;
    logic [RW+1:0]          n_r2;
    logic                   n_ge;

    always_comb begin
        n_q0 = (i_num >= NW'(i_den));
        n_r2 = {r_r, 1'b0};
        n_ge = (n_r2 >= (RW+2)'(r_den));
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= WEIGHT_BITS'(n_q0);
            r_r   <= (RW+1)'(i_num - (n_q0 ? NW'(i_den) : '0));
            r_den <= i_den;
        end else if (r_busy) begin
            r_q <= {r_q[WEIGHT_BITS-2:0], n_ge};
            r_r <= (RW+1)'(n_ge ? (n_r2 - (RW+2)'(r_den)) : n_r2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(FRAC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

@@ hdl/chunk_boundary_falloff_weight_unit.sv @@
// Top level of the chunk boundary falloff weight unit.
//
//   Channel   Dir  Word contents (lowest bit first)
//   s_axis    in   tdata: slot[3:0], coord_x, coord_y, coord_z, zero pad; tuser: func
//   m_axis    out  tdata: weight[16:0], zero pad to 24 bits
//   cfg       in   i_cfg_we / i_cfg_idx / i_cfg_data: num_centers, own_chunk
//
// A load word writes one cell of the center ring. A weigh word rotates the ring
// once through one shared distance pipeline of COORD_BITS+5 stages, then notices
// the last distance, checks the thresholds and, in the falloff band, runs the
// serial divider. The next word can be taken once the weight has moved to the
// output register. Reset is synchronous, active low; it resets control and
// configuration but not the ring. The input stalls while a weigh word is in
// work; a finished weight waits in the output register and does not hold off
// the next input word, but a following weight waits in its final state until
// the output register is free.
`timescale 1ns / 1ps
module chunk_boundary_falloff_weight_unit #(
    parameter int MAX_CENTERS = cbfw_pkg::MAX_CENTERS_DEF,
    parameter int COORD_BITS  = cbfw_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // slot[3:0], x[35:4], y[67:36], z[99:68], pad
    input  logic         s_axis_tuser,   // func
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // weight[16:0], pad
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [4:0]   i_cfg_data
);
    import cbfw_pkg::*;

    localparam int IW = (MAX_CENTERS > 1) ? $clog2(MAX_CENTERS) : 1;
    localparam int CW = IW + 1;
    localparam int RW = COORD_BITS + 2;
    localparam int NW = RW + 5;

    t_state r_state, n_state;

    logic [CW-1:0] r_ncent;   // clamped count of slots in use
    logic [IW-1:0] r_own;     // own slot reduced into the table
    logic [CW-1:0] r_issue, r_ret;
    logic signed [COORD_BITS-1:0] r_px, r_py, r_pz;
    logic [RW-1:0] r_d, r_m;
    logic          r_have;
    logic          r_ovalid;
    logic [WEIGHT_BITS-1:0] r_weight;

    logic signed [COORD_BITS-1:0] w_inx, w_iny, w_inz;
    logic signed [COORD_BITS-1:0] w_cx [0:MAX_CENTERS-1];
    logic signed [COORD_BITS-1:0] w_cy [0:MAX_CENTERS-1];
    logic signed [COORD_BITS-1:0] w_cz [0:MAX_CENTERS-1];

    logic            w_acc, w_shift;
    logic            w_dvalid;
    logic [IW-1:0]   w_dtag;
    logic [RW-1:0]   w_dist;
    logic            w_div_start, w_div_done;
    logic [WEIGHT_BITS-1:0] w_quot;
    logic [NW-1:0]   w_d20, w_m19, w_m21;
    logic [4:0]      n_cnt_clamp;
    logic [3:0]      n_own_red;
    logic            w_out_free;

    generate
        if (COORD_BITS <= 32) begin : g_narrow
            assign w_inx = s_axis_tdata[4 +: COORD_BITS];
            assign w_iny = s_axis_tdata[36 +: COORD_BITS];
            assign w_inz = s_axis_tdata[68 +: COORD_BITS];
        end else begin : g_wide
            assign w_inx = COORD_BITS'($signed(s_axis_tdata[35:4]));
            assign w_iny = COORD_BITS'($signed(s_axis_tdata[67:36]));
            assign w_inz = COORD_BITS'($signed(s_axis_tdata[99:68]));
        end
    endgenerate

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_shift = (r_state == S_SCAN);

    // The ring: cell i takes its right neighbor, the last cell wraps to cell 0.
    // After k shifts cell 0 holds slot k; a full turn brings every slot home.
    for (genvar i = 0; i < MAX_CENTERS; i++) begin : g_ring
        localparam int NB = (i + 1) % MAX_CENTERS;
        cbfw_cell #(.COORD_BITS(COORD_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_load  (w_acc && (s_axis_tuser == FUNC_LOAD) &&
                      ({4'd0, s_axis_tdata[3:0]} == 8'(i))),
            .i_shift (w_shift),
            .i_load_x(w_inx),
            .i_load_y(w_iny),
            .i_load_z(w_inz),
            .i_nb_x  (w_cx[NB]),
            .i_nb_y  (w_cy[NB]),
            .i_nb_z  (w_cz[NB]),
            .o_x     (w_cx[i]),
            .o_y     (w_cy[i]),
            .o_z     (w_cz[i])
        );
    end

    cbfw_dist #(.COORD_BITS(COORD_BITS), .TAG_BITS(IW)) u_dist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(w_shift),
        .i_tag  (r_issue[IW-1:0]),
        .i_px   (r_px),
        .i_py   (r_py),
        .i_pz   (r_pz),
        .i_cx   (w_cx[0]),
        .i_cy   (w_cy[0]),
        .i_cz   (w_cz[0]),
        .o_valid(w_dvalid),
        .o_tag  (w_dtag),
        .o_dist (w_dist)
    );

    always_comb begin
        w_d20 = NW'(r_d) * NW'(20);
        w_m19 = NW'(r_m) * NW'(19);
        w_m21 = NW'(r_m) * NW'(21);
    end

    cbfw_div #(.RW(RW)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_m21 - w_d20),
        .i_den  (r_m),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    // Configuration: the count saturates at the table size, the own slot
    // wraps into the table by repeated subtraction (at most eight steps).
    always_comb begin
        n_cnt_clamp = (32'(i_cfg_data) > MAX_CENTERS) ? 5'(MAX_CENTERS) : i_cfg_data;
        n_own_red   = i_cfg_data[3:0];
        for (int k = 0; k < 8; k++) begin
            if (32'(n_own_red) >= MAX_CENTERS) begin
                n_own_red = 4'(32'(n_own_red) - MAX_CENTERS);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncent <= CW'(1);
            r_own   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NUM_CENTERS) begin
                r_ncent <= CW'(n_cnt_clamp);
            end else begin
                r_own <= IW'(n_own_red);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_px <= w_inx;
            r_py <= w_iny;
            r_pz <= w_inz;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_out_free = !r_ovalid || m_axis_tready;

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_acc && (s_axis_tuser == FUNC_WEIGH)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_issue == CW'(MAX_CENTERS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_ret == CW'(MAX_CENTERS)) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_have && (r_m != '0) && !(w_d20 <= w_m19) && !(w_d20 > w_m21)) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIVIDE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIVIDE: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Issue and return counters of the ring turn.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue <= '0;
            r_ret   <= '0;
        end else if (r_state == S_IDLE) begin
            r_issue <= '0;
            r_ret   <= '0;
        end else begin
            if (w_shift) begin
                r_issue <= r_issue + CW'(1);
            end
            if (w_dvalid) begin
                r_ret <= r_ret + CW'(1);
            end
        end
    end

    // Distances come back in slot order; the own slot gives d, every other
    // slot below the count competes for the least distance m.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
        end else if (r_state == S_IDLE) begin
            r_have <= 1'b0;
        end else if (w_dvalid && (w_dtag != r_own) && (CW'(w_dtag) < r_ncent)) begin
            r_have <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dvalid) begin
            if (w_dtag == r_own) begin
                r_d <= w_dist;
            end else if ((CW'(w_dtag) < r_ncent) && (!r_have || (w_dist < r_m))) begin
                r_m <= w_dist;
            end
        end
    end

    // Result register: the weight is settled in the decide step, or by the divider.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            if (!r_have) begin
                r_weight <= WEIGHT_ONE;
            end else if (r_m == '0) begin
                r_weight <= (r_d == '0) ? WEIGHT_ONE : '0;
            end else if (w_d20 <= w_m19) begin
                r_weight <= WEIGHT_ONE;
            end else begin
                r_weight <= '0;
            end
        end else if ((r_state == S_DIVIDE) && w_div_done) begin
            r_weight <= (w_quot > WEIGHT_ONE) ? WEIGHT_ONE : w_quot;
        end
    end

    logic [WEIGHT_BITS-1:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_odata <= r_weight;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {7'd0, r_odata};

`include "chunk_boundary_falloff_weight_unit_assert.svh"

    `CBFW_ASSERT_NOW(a_ret_le_issue, 1'b1, r_ret <= r_issue)
    `CBFW_ASSERT_NOW(a_decide_full, r_state == S_DECIDE, r_ret == CW'(MAX_CENTERS))
    `CBFW_ASSERT_NOW(a_weight_range, m_axis_tvalid, m_axis_tdata[16:0] <= WEIGHT_ONE)
    `CBFW_ASSERT_NEXT(a_scan_no_input, r_state == S_SCAN, !s_axis_tready)
endmodule
